// ===== rtl/rgb_to_hsv_pixel_macros.svh =====
// Assertion macros for the RGB to HSV pixel converter.
`ifndef RGB_TO_HSV_PIXEL_MACROS_SVH
`define RGB_TO_HSV_PIXEL_MACROS_SVH

`ifndef SYNTH
`define RHSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RHSV_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RHSV_ASSERT(lbl, prop, msg)
`define RHSV_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== rtl/rhsv_pkg.sv =====
// Shared types, constants and the divider step for the RGB to HSV converter.
package rhsv_pkg;

  localparam int PIX_W         = 8;
  localparam int NUM_W         = 17;  // hue numerator stays below 360 * 255
  localparam int DEN_W         = 9;   // hue divisor is 2 * chroma
  localparam int Q_W           = 8;
  localparam int BITS_PER_STEP = 2;
  localparam int DIV_STEPS     = Q_W / BITS_PER_STEP;
  localparam int NUM_STAGES    = 2 + DIV_STEPS;

  // hue offset codes, in degrees
  localparam logic [1:0] OFF_0   = 2'd0;
  localparam logic [1:0] OFF_120 = 2'd1;
  localparam logic [1:0] OFF_240 = 2'd2;
  localparam logic [1:0] OFF_360 = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] mx;
    logic [PIX_W-1:0] d;
    logic [PIX_W:0]   diff;  // two's complement, -255..255
    logic [1:0]       off;
  } srt_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   q;
  } dv_t;

  typedef struct packed {
    dv_t              hue;
    dv_t              sat;
    logic [PIX_W-1:0] mx;
  } dvs_t;

  // one restoring step: quotient bit b
  function automatic dv_t div_step(dv_t x, logic [2:0] b);
    logic [NUM_W-1:0] sh;
    dv_t              y;
    y  = x;
    sh = NUM_W'(x.den) << b;
    if (y.rem >= sh) begin
      y.rem  = y.rem - sh;
      y.q[b] = 1'b1;
    end
    return y;
  endfunction

endpackage

// ===== rtl/rhsv_sort.sv =====
// Stage 1: max, chroma, hue sector and signed difference.
module rhsv_sort (
  input  logic                      clk,
  input  logic                      load,
  input  logic [rhsv_pkg::PIX_W-1:0] red,
  input  logic [rhsv_pkg::PIX_W-1:0] green,
  input  logic [rhsv_pkg::PIX_W-1:0] blue,
  output rhsv_pkg::srt_t            srt
);
  import rhsv_pkg::*;

  logic [PIX_W-1:0] mx, mn, rg_max, rg_min;
  srt_t             srt_next;

  always_comb begin
    rg_max = (red > green) ? red : green;
    mx     = (rg_max > blue) ? rg_max : blue;
    rg_min = (red < green) ? red : green;
    mn     = (rg_min < blue) ? rg_min : blue;
    srt_next.mx = mx;
    srt_next.d  = mx - mn;
    // green wins ties, then red
    if (green == mx) begin
      srt_next.diff = {1'b0, blue} - {1'b0, red};
      srt_next.off  = OFF_120;
    end else if (red == mx) begin
      srt_next.diff = {1'b0, green} - {1'b0, blue};
      srt_next.off  = (green < blue) ? OFF_360 : OFF_0;
    end else begin
      srt_next.diff = {1'b0, red} - {1'b0, green};
      srt_next.off  = OFF_240;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      srt <= srt_next;
    end
  end

endmodule

// ===== rtl/rhsv_numer.sv =====
// Stage 2: dividends and divisors for hue and saturation.
module rhsv_numer (
  input  logic           clk,
  input  logic           load,
  input  rhsv_pkg::srt_t srt,
  output rhsv_pkg::dvs_t dvs
);
  import rhsv_pkg::*;

  logic [DEN_W-1:0]  off_val;
  logic [NUM_W-1:0]  off_d;
  logic [NUM_W+1:0]  hnum;
  dvs_t              dvs_next;

  always_comb begin
    case (srt.off)
      OFF_0:   off_val = DEN_W'(0);
      OFF_120: off_val = DEN_W'(120);
      OFF_240: off_val = DEN_W'(240);
      default: off_val = DEN_W'(360);
    endcase
    off_d = NUM_W'(srt.d) * NUM_W'(off_val);
    // 60*diff + off*d is never negative; wraparound arithmetic is exact
    hnum  = {{(NUM_W+1-PIX_W){srt.diff[PIX_W]}}, srt.diff} * (NUM_W+2)'(60)
            + (NUM_W+2)'(off_d);

    dvs_next.mx = srt.mx;
    dvs_next.hue.q = '0;
    dvs_next.sat.q = '0;
    // grey / black: zero dividend over one gives zero
    if (srt.d == '0) begin
      dvs_next.hue.rem = '0;
      dvs_next.hue.den = DEN_W'(1);
    end else begin
      dvs_next.hue.rem = hnum[NUM_W-1:0];
      dvs_next.hue.den = {srt.d, 1'b0};
    end
    dvs_next.sat.rem = NUM_W'({srt.d, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, srt.d});
    dvs_next.sat.den = (srt.mx == '0) ? DEN_W'(1) : DEN_W'(srt.mx);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dvs <= dvs_next;
    end
  end

endmodule

// ===== rtl/rhsv_div_stage.sv =====
// One divider stage: two quotient bits for both hue and saturation.
module rhsv_div_stage #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           load,
  input  rhsv_pkg::dvs_t din,
  output rhsv_pkg::dvs_t dout
);
  import rhsv_pkg::*;

  localparam int B_HI = Q_W - 1 - BITS_PER_STEP * STEP;

  dvs_t dout_next;

  always_comb begin
    dout_next = din;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      dout_next.hue = div_step(dout_next.hue, 3'(B_HI - i));
      dout_next.sat = div_step(dout_next.sat, 3'(B_HI - i));
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= dout_next;
    end
  end

endmodule

// ===== rtl/rgb_to_hsv_pixel.sv =====
// Top level: RGB to HSV pixel converter, six-stage pipeline.
//
//  channel | signals                        | direction
//  --------+--------------------------------+----------
//  pix     | pix_valid pix_ready red green blue | in
//  hsv     | hsv_valid hsv_ready hue saturation value | out
//
// One pixel per clock while hsv_ready is high; the stages are sort, dividend setup and four divider
// stages of two quotient bits each. The last divider stage is the output register.
// Each stage holds its own valid bit and advances when empty or when the next stage
// moves, so bubbles are squeezed out under a stall and pix_ready stays high until
// every stage is full. Synchronous reset clears the valid bits only.
`include "rgb_to_hsv_pixel_macros.svh"

module rgb_to_hsv_pixel (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       pix_valid,
  output logic                       pix_ready,
  input  logic [rhsv_pkg::PIX_W-1:0] red,
  input  logic [rhsv_pkg::PIX_W-1:0] green,
  input  logic [rhsv_pkg::PIX_W-1:0] blue,
  output logic                       hsv_valid,
  input  logic                       hsv_ready,
  output logic [rhsv_pkg::Q_W-1:0]   hue,
  output logic [rhsv_pkg::Q_W-1:0]   saturation,
  output logic [rhsv_pkg::PIX_W-1:0] value
);
  import rhsv_pkg::*;

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES:0]   rdy;
  logic [NUM_STAGES-1:0] vin;
  logic [NUM_STAGES-1:0] load;
  srt_t                  srt;
  dvs_t                  dvs [0:DIV_STEPS];

  always_comb begin
    rdy[NUM_STAGES] = hsv_ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
    vin = {vld[NUM_STAGES-2:0], pix_valid};
    load = vin & rdy[NUM_STAGES-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (rdy[k]) begin
          vld[k] <= vin[k];
        end
      end
    end
  end

  rhsv_sort u_sort (
    .clk   (clk),
    .load  (load[0]),
    .red   (red),
    .green (green),
    .blue  (blue),
    .srt   (srt)
  );

  rhsv_numer u_numer (
    .clk  (clk),
    .load (load[1]),
    .srt  (srt),
    .dvs  (dvs[0])
  );

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    rhsv_div_stage #(
      .STEP (s)
    ) u_div (
      .clk  (clk),
      .load (load[2+s]),
      .din  (dvs[s]),
      .dout (dvs[s+1])
    );
  end

  assign pix_ready  = rdy[0];
  assign hsv_valid  = vld[NUM_STAGES-1];
  assign hue        = dvs[DIV_STEPS].hue.q;
  assign saturation = dvs[DIV_STEPS].sat.q;
  assign value      = dvs[DIV_STEPS].mx;

  `RHSV_ASSERT_RST(a_rst_empty, rst |=> !hsv_valid, "output beat right after reset")
  `RHSV_ASSERT(a_hue_range, hsv_valid |-> (hue <= 8'd179), "hue out of range")
  `RHSV_ASSERT(a_black_sat, (hsv_valid && value == '0) |-> (saturation == '0), "sat on black")
  `RHSV_ASSERT(a_full_stall, !pix_ready |-> (&vld && !hsv_ready), "stall with room")

endmodule

// ===== test/rgb_to_hsv_checker.sv =====
// Checker for the RGB to HSV converter: predicts each pixel's HSV and compares output beats.
`timescale 1ns / 1ps

module rgb_to_hsv_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       pix_valid,
  input  logic                       pix_ready,
  input  logic [rhsv_pkg::PIX_W-1:0] red,
  input  logic [rhsv_pkg::PIX_W-1:0] green,
  input  logic [rhsv_pkg::PIX_W-1:0] blue,
  input  logic                       hsv_valid,
  input  logic                       hsv_ready,
  input  logic [rhsv_pkg::Q_W-1:0]   hue,
  input  logic [rhsv_pkg::Q_W-1:0]   saturation,
  input  logic [rhsv_pkg::PIX_W-1:0] value,
  output int                         fail_count,
  output int                         pending
);

  // hue offsets in degrees for each winning channel
  localparam int HUE_OFF_RED      = 0;
  localparam int HUE_OFF_GREEN    = 120;
  localparam int HUE_OFF_BLUE     = 240;
  localparam int HUE_OFF_RED_WRAP = 360;
  localparam int HUE_MAX          = 179;
  localparam int FULL_SCALE       = 255;

  typedef struct packed {
    logic [rhsv_pkg::Q_W-1:0]   h;
    logic [rhsv_pkg::Q_W-1:0]   s;
    logic [rhsv_pkg::PIX_W-1:0] v;
  } hsv_t;

  hsv_t hsv_due[$];
  int   mismatches = 0;

  function automatic hsv_t convert_pixel(logic [rhsv_pkg::PIX_W-1:0] r8,
                                         logic [rhsv_pkg::PIX_W-1:0] g8,
                                         logic [rhsv_pkg::PIX_W-1:0] b8);
    int   r, g, b, mx, mn, chroma, diff, offs, num, h, s;
    hsv_t res;
    r  = int'(r8);
    g  = int'(g8);
    b  = int'(b8);
    mx = (r > g) ? r : g;
    mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
    chroma = mx - mn;
    s = (mx != 0) ? (FULL_SCALE * chroma) / mx : 0;
    h = 0;
    if (chroma != 0) begin
      // green wins ties, then red, then blue
      if (g == mx) begin
        diff = b - r;
        offs = HUE_OFF_GREEN;
      end else if (r == mx) begin
        diff = g - b;
        offs = (g < b) ? HUE_OFF_RED_WRAP : HUE_OFF_RED;
      end else begin
        diff = r - g;
        offs = HUE_OFF_BLUE;
      end
      num = 60 * diff + offs * chroma;
      if (num < 0) num = 0;
      h = num / (2 * chroma);
      if (h > HUE_MAX) h = HUE_MAX;
    end
    res.h = h[rhsv_pkg::Q_W-1:0];
    res.s = s[rhsv_pkg::Q_W-1:0];
    res.v = mx[rhsv_pkg::PIX_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    hsv_t want;
    if (!rst) begin
      if (pix_valid && pix_ready) hsv_due.push_back(convert_pixel(red, green, blue));
      if (hsv_valid && hsv_ready) begin
        if (hsv_due.size() == 0) begin
          $display("%0t: unexpected beat hue %0d sat %0d value %0d",
                   $time, hue, saturation, value);
          mismatches++;
        end else begin
          want = hsv_due.pop_front();
          if (hue !== want.h) begin
            $display("%0t: hue expected %0d got %0d", $time, want.h, hue);
            mismatches++;
          end
          if (saturation !== want.s) begin
            $display("%0t: saturation expected %0d got %0d", $time, want.s, saturation);
            mismatches++;
          end
          if (value !== want.v) begin
            $display("%0t: value expected %0d got %0d", $time, want.v, value);
            mismatches++;
          end
        end
      end
      fail_count <= mismatches;
      pending    <= hsv_due.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
// Top of the RGB to HSV converter test: stimulus, backpressure, watchdog and verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int RANDOM_PIXELS  = 1850;
  localparam int IDLE_LIMIT     = 3000;
  localparam int HOLD_AFTER     = 300;  // pixels sent before the long receiver hold-off
  localparam int HOLD_CYCLES    = 150;
  localparam int DRAIN_CYCLES   = 20;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       pix_valid;
  logic                       pix_ready;
  logic [rhsv_pkg::PIX_W-1:0] red, green, blue;
  logic                       hsv_valid;
  logic                       hsv_ready;
  logic [rhsv_pkg::Q_W-1:0]   hue, saturation;
  logic [rhsv_pkg::PIX_W-1:0] value;
  int                         fail_count, pending;
  int                         sent_count = 0;
  int                         idle_cycles = 0;
  bit                         held_off = 1'b0;

  rgb_to_hsv_pixel dut (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_ready(pix_ready),
    .red(red), .green(green), .blue(blue),
    .hsv_valid(hsv_valid), .hsv_ready(hsv_ready),
    .hue(hue), .saturation(saturation), .value(value)
  );

  rgb_to_hsv_checker chk (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_ready(pix_ready),
    .red(red), .green(green), .blue(blue),
    .hsv_valid(hsv_valid), .hsv_ready(hsv_ready),
    .hue(hue), .saturation(saturation), .value(value),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] edge_level();
    case ($urandom_range(0, 4))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd254;
      3: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_valid <= 1'b1;
    red       <= r;
    green     <= g;
    blue      <= b;
    @(posedge clk);
    while (!pix_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_random_pixel();
    logic [7:0] a, c, lo;
    int         kind;
    a    = 8'($urandom);
    c    = 8'($urandom);
    kind = $urandom_range(0, 99);
    if (kind < 50) begin
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    end else if (kind < 62) begin
      send_pixel(a, a, a);
    end else if (kind < 77) begin
      // two channels tie, third random
      case ($urandom_range(0, 2))
        0: send_pixel(a, a, c);
        1: send_pixel(a, c, a);
        default: send_pixel(c, a, a);
      endcase
    end else if (kind < 90) begin
      send_pixel(edge_level(), edge_level(), edge_level());
    end else begin
      // nearly grey: small chroma
      lo = (a > 8'd250) ? 8'd250 : a;
      send_pixel(lo + 8'($urandom_range(0, 5)), lo + 8'($urandom_range(0, 5)),
                 lo + 8'($urandom_range(0, 5)));
    end
  endtask

  // receiver: random ready pattern plus one long hold-off to fill the pipeline
  initial begin
    int run, gap;
    hsv_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held_off && sent_count >= HOLD_AFTER) begin
        hsv_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held_off = 1'b1;
      end else begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
        hsv_ready <= 1'b1;
        repeat (run) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          hsv_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pix_valid && pix_ready) || (hsv_valid && hsv_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst       <= 1'b1;
    pix_valid <= 1'b0;
    red       <= '0;
    green     <= '0;
    blue      <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: black, white, greys, primaries, ties, red wrap, extremes
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd1,   8'd1,   8'd1);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd255, 8'd0,   8'd1);
    send_pixel(8'd255, 8'd1,   8'd0);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd1,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd254, 8'd255, 8'd0);
    send_pixel(8'd10,  8'd0,   8'd255);
    send_pixel(8'd0,   8'd255, 8'd254);
    send_pixel(8'd85,  8'd170, 8'd255);
    send_pixel(8'd200, 8'd100, 8'd50);
    send_pixel(8'd170, 8'd85,  8'd170);

    repeat (RANDOM_PIXELS) send_random_pixel();
    pix_valid <= 1'b0;

    // let the checker count the last beat before watching pending
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
